FILE: rtl/lmsn_pkg.sv
`timescale 1ns / 1ps

package lmsn_pkg;

    localparam int INPUT_COUNT = 3;
    localparam int IDX_W       = 2;

    // input queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // epoch mean divider: three 16-bit quotient digits, each with an estimate step and a remainder step
    localparam int DIV_STEPS = 6;
    localparam int DIV_CNT_W = 3;

    localparam logic [15:0] LEARNING_RATE_RESET   = 16'd6554;
    localparam logic [47:0] ERROR_THRESHOLD_RESET = 48'd43;
    localparam logic [15:0] MAX_EPOCHS_RESET      = 16'd4000;
    localparam logic [31:0] INIT_WEIGHT_RESET     = 32'd2097152;

    typedef struct packed {
        logic signed [15:0] x_a;
        logic signed [15:0] x_b;
        logic signed [15:0] x_c;
        logic signed [15:0] target;
        logic               restart;
    } item_t;

    typedef struct packed {
        logic signed [31:0] prediction;
        logic        [47:0] squared_error;
        logic               epoch_end;
        logic        [47:0] mean_error;
        logic               converged;
        logic               training_active;
        logic signed [31:0] weight_a_out;
        logic signed [31:0] weight_b_out;
        logic signed [31:0] weight_c_out;
    } result_t;

    typedef struct packed {
        logic [15:0]                        learning_rate;
        logic [47:0]                        error_threshold;
        logic [15:0]                        max_epochs;
        logic [INPUT_COUNT-1:0][31:0]       init_weight;
    } cfg_t;

endpackage

FILE: rtl/lmsn_front.sv
`timescale 1ns / 1ps

module lmsn_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [63:0]         s_tdata,   // x_a, x_b, x_c, target
    input  logic [0:0]          s_tuser,   // restart
    output logic                q_valid,
    output lmsn_pkg::item_t     q_item,
    input  logic                q_pop
);

    lmsn_pkg::item_t                    q_mem [lmsn_pkg::QUEUE_DEPTH];
    logic [lmsn_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [lmsn_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [lmsn_pkg::QCNT_W-1:0]        count_reg;
    logic [lmsn_pkg::QCNT_W-1:0]        count_next;
    lmsn_pkg::item_t                    in_item;
    logic                               push;
    logic                               pop;

    // unpack the stream word into the sample fields
    always_comb
    begin
        in_item.x_a     = $signed(s_tdata[15:0]);
        in_item.x_b     = $signed(s_tdata[31:16]);
        in_item.x_c     = $signed(s_tdata[47:32]);
        in_item.target  = $signed(s_tdata[63:48]);
        in_item.restart = s_tuser[0];
    end

    assign s_tready = (count_reg != lmsn_pkg::QCNT_W'(lmsn_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

FILE: rtl/lmsn_back.sv
`timescale 1ns / 1ps

module lmsn_back
#(
    parameter int SAMPLES_PER_EPOCH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lmsn_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  lmsn_pkg::item_t     q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output lmsn_pkg::result_t   out_res
);

    localparam int SAMP_W = (SAMPLES_PER_EPOCH > 1) ? $clog2(SAMPLES_PER_EPOCH) : 1;
    localparam logic [SAMP_W-1:0] LAST_SAMPLE = SAMP_W'(SAMPLES_PER_EPOCH - 1);
    localparam logic [lmsn_pkg::IDX_W-1:0] LAST_IDX =
        lmsn_pkg::IDX_W'(lmsn_pkg::INPUT_COUNT - 1);

    // reciprocal of the epoch length, exact for a 24-bit partial dividend
    localparam int          DIV_L  = $clog2(SAMPLES_PER_EPOCH);
    localparam int          DIV_SH = 24 + DIV_L;
    localparam logic [25:0] DIV_M  =
        26'(((64'd1 << DIV_SH) + 64'(SAMPLES_PER_EPOCH) - 64'd1) / 64'(SAMPLES_PER_EPOCH));
    localparam logic [8:0]  DIV_D  = 9'(SAMPLES_PER_EPOCH);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DOT   = 4'd1;
    localparam logic [3:0] ST_SUM   = 4'd2;
    localparam logic [3:0] ST_PRED  = 4'd3;
    localparam logic [3:0] ST_ERR   = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_SQR   = 4'd6;
    localparam logic [3:0] ST_UPD1  = 4'd7;
    localparam logic [3:0] ST_UPD2  = 4'd8;
    localparam logic [3:0] ST_UPD3  = 4'd9;
    localparam logic [3:0] ST_UPD4  = 4'd10;
    localparam logic [3:0] ST_UPD5  = 4'd11;
    localparam logic [3:0] ST_ACCUM = 4'd12;
    localparam logic [3:0] ST_DIV   = 4'd13;
    localparam logic [3:0] ST_EPOCH = 4'd14;
    localparam logic [3:0] ST_OUT   = 4'd15;

    logic [3:0]                     state_reg;
    logic [lmsn_pkg::IDX_W-1:0]     idx_reg;
    logic signed [31:0]             w_reg [lmsn_pkg::INPUT_COUNT];
    logic signed [15:0]             x_reg [lmsn_pkg::INPUT_COUNT];
    logic signed [15:0]             tgt_reg;
    logic signed [55:0]             prod_reg;
    logic signed [49:0]             acc_reg;
    logic signed [31:0]             pred_reg;
    logic        [32:0]             err_reg;
    logic        [63:0]             sq_prod_reg;
    logic        [47:0]             sq_reg;
    logic signed [37:0]             p_reg;
    logic signed [37:0]             d_reg;
    logic        [47:0]             sum_reg;
    logic        [SAMP_W-1:0]       samp_reg;
    logic        [15:0]             epoch_reg;
    logic                           done_reg;
    logic                           active_reg;
    logic                           ep_end_reg;
    logic                           conv_reg;
    logic        [47:0]             mean_reg;
    logic        [47:0]             div_num_reg;
    logic        [7:0]              div_rem_reg;
    logic        [15:0]             div_q_reg;
    logic        [lmsn_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic                           out_valid_reg;
    lmsn_pkg::result_t              res_reg;

    logic signed [37:0]             mul_a;
    logic signed [17:0]             mul_b;
    logic signed [55:0]             mul_p;
    logic        [31:0]             err_abs;
    logic        [32:0]             err_neg;
    logic        [63:0]             sq_mul;
    logic signed [31:0]             pred_next;
    logic        [47:0]             sq_next;
    logic signed [37:0]             p_next;
    logic signed [37:0]             d_next;
    logic signed [31:0]             w_new;
    logic        [47:0]             sum_next;
    logic        [47:0]             div_num_next;
    logic        [7:0]              div_rem_next;
    logic        [15:0]             div_q_next;
    logic                           conv_next;
    logic        [15:0]             epoch_next;
    logic        [15:0]             epoch_limit;
    logic                           out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    // shared multiplier: dot product terms, error times input, step times rate
    always_comb
    begin
        unique case (state_reg)
            ST_UPD1:
            begin
                mul_a = $signed({{5{err_reg[32]}}, err_reg});
                mul_b = $signed({{2{x_reg[idx_reg][15]}}, x_reg[idx_reg]});
            end
            ST_UPD3:
            begin
                mul_a = p_reg;
                mul_b = $signed({2'b00, cfg.learning_rate});
            end
            default:
            begin
                mul_a = $signed({{6{w_reg[idx_reg][31]}}, w_reg[idx_reg]});
                mul_b = $signed({{2{x_reg[idx_reg][15]}}, x_reg[idx_reg]});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign err_neg = 33'd0 - err_reg;
    assign err_abs = err_reg[32] ? err_neg[31:0] : err_reg[31:0];
    assign sq_mul  = err_abs * err_abs;

    // round half up and saturate the dot product
    always_comb
    begin
        logic signed [49:0] acc_rnd;
        logic signed [37:0] acc_sh;
        acc_rnd = acc_reg + 50'sd2048;
        acc_sh  = acc_rnd[49:12];
        if (!acc_sh[37] && (|acc_sh[36:31]))
        begin
            pred_next = 32'sh7fffffff;
        end
        else if (acc_sh[37] && !(&acc_sh[36:31]))
        begin
            pred_next = 32'sh80000000;
        end
        else
        begin
            pred_next = acc_sh[31:0];
        end
    end

    always_comb
    begin
        logic [63:0] sq_rnd;
        sq_rnd  = sq_prod_reg + 64'd128;
        sq_next = (|sq_rnd[63:56]) ? 48'hffffffffffff : sq_rnd[55:8];
    end

    always_comb
    begin
        logic signed [49:0] p_rnd;
        logic signed [55:0] d_rnd;
        p_rnd  = prod_reg[49:0] + 50'sd2048;
        p_next = p_rnd[49:12];
        d_rnd  = prod_reg + 56'sd32768;
        d_next = d_rnd[53:16];
    end

    always_comb
    begin
        logic signed [38:0] w_diff;
        w_diff = $signed({{7{w_reg[idx_reg][31]}}, w_reg[idx_reg]}) -
                 $signed({d_reg[37], d_reg});
        if (!w_diff[38] && (|w_diff[37:31]))
        begin
            w_new = 32'sh7fffffff;
        end
        else if (w_diff[38] && !(&w_diff[37:31]))
        begin
            w_new = 32'sh80000000;
        end
        else
        begin
            w_new = w_diff[31:0];
        end
    end

    always_comb
    begin
        logic [48:0] sum_wide;
        sum_wide = {1'b0, sum_reg} + {1'b0, sq_reg};
        sum_next = sum_wide[48] ? 48'hffffffffffff : sum_wide[47:0];
    end

    // long division by the epoch length in 16-bit digits: estimate each digit
    // by reciprocal multiplication, then form the remainder on the next cycle
    always_comb
    begin
        logic [23:0] div_part;
        logic [49:0] q_prod;
        logic [24:0] qd_prod;
        logic [24:0] rem_wide;
        div_part     = {div_rem_reg, div_num_reg[47:32]};
        q_prod       = {26'd0, div_part} * {24'd0, DIV_M};
        div_q_next   = 16'(q_prod >> DIV_SH);
        qd_prod      = {9'd0, div_q_reg} * {16'd0, DIV_D};
        rem_wide     = {1'b0, div_part} - qd_prod;
        div_rem_next = rem_wide[7:0];
        div_num_next = {div_num_reg[31:0], div_q_reg};
    end

    assign conv_next   = (div_num_reg <= cfg.error_threshold);
    assign epoch_next  = epoch_reg + 16'd1;
    assign epoch_limit = (cfg.max_epochs == 16'd0) ? 16'd1 : cfg.max_epochs;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    x_reg[0] <= q_item.x_a;
                    x_reg[1] <= q_item.x_b;
                    x_reg[2] <= q_item.x_c;
                    tgt_reg  <= q_item.target;
                end
            end
            ST_DOT:
            begin
                prod_reg <= mul_p;
                acc_reg  <= (idx_reg == '0) ? 50'sd0 : acc_reg + prod_reg[49:0];
            end
            ST_SUM:
            begin
                acc_reg <= acc_reg + prod_reg[49:0];
            end
            ST_PRED:
            begin
                pred_reg <= pred_next;
            end
            ST_ERR:
            begin
                err_reg <= {pred_reg[31], pred_reg} - {{9{tgt_reg[15]}}, tgt_reg, 8'h00};
            end
            ST_SQ:
            begin
                sq_prod_reg <= sq_mul;
            end
            ST_SQR:
            begin
                sq_reg <= sq_next;
            end
            ST_UPD1, ST_UPD3:
            begin
                prod_reg <= mul_p;
            end
            ST_UPD2:
            begin
                p_reg <= p_next;
            end
            ST_UPD4:
            begin
                d_reg <= d_next;
            end
            ST_ACCUM:
            begin
                div_num_reg <= sum_next;
                div_rem_reg <= '0;
            end
            ST_DIV:
            begin
                if (!div_cnt_reg[0])
                begin
                    div_q_reg <= div_q_next;
                end
                else
                begin
                    div_num_reg <= div_num_next;
                    div_rem_reg <= div_rem_next;
                end
            end
            ST_EPOCH:
            begin
                mean_reg <= div_num_reg;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    res_reg.prediction      <= pred_reg;
                    res_reg.squared_error   <= sq_reg;
                    res_reg.epoch_end       <= ep_end_reg;
                    res_reg.mean_error      <= ep_end_reg ? mean_reg : 48'd0;
                    res_reg.converged       <= conv_reg;
                    res_reg.training_active <= active_reg;
                    res_reg.weight_a_out    <= w_reg[0];
                    res_reg.weight_b_out    <= w_reg[1];
                    res_reg.weight_c_out    <= w_reg[2];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            for (int k = 0; k < lmsn_pkg::INPUT_COUNT; k++)
            begin
                w_reg[k] <= $signed(lmsn_pkg::INIT_WEIGHT_RESET);
            end
            sum_reg       <= '0;
            samp_reg      <= '0;
            epoch_reg     <= '0;
            done_reg      <= 1'b0;
            active_reg    <= 1'b0;
            ep_end_reg    <= 1'b0;
            conv_reg      <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.restart)
                        begin
                            for (int k = 0; k < lmsn_pkg::INPUT_COUNT; k++)
                            begin
                                w_reg[k] <= $signed(cfg.init_weight[k]);
                            end
                            sum_reg   <= '0;
                            samp_reg  <= '0;
                            epoch_reg <= '0;
                            done_reg  <= 1'b0;
                        end
                        ep_end_reg <= 1'b0;
                        conv_reg   <= 1'b0;
                        idx_reg    <= '0;
                        state_reg  <= ST_DOT;
                    end
                end
                ST_DOT:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_SUM;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_SUM:
                begin
                    state_reg <= ST_PRED;
                end
                ST_PRED:
                begin
                    state_reg <= ST_ERR;
                end
                ST_ERR:
                begin
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    state_reg <= ST_SQR;
                end
                ST_SQR:
                begin
                    active_reg <= !done_reg;
                    idx_reg    <= '0;
                    state_reg  <= done_reg ? ST_OUT : ST_UPD1;
                end
                ST_UPD1:
                begin
                    state_reg <= ST_UPD2;
                end
                ST_UPD2:
                begin
                    state_reg <= ST_UPD3;
                end
                ST_UPD3:
                begin
                    state_reg <= ST_UPD4;
                end
                ST_UPD4:
                begin
                    state_reg <= ST_UPD5;
                end
                ST_UPD5:
                begin
                    w_reg[idx_reg] <= w_new;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_ACCUM;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_UPD1;
                    end
                end
                ST_ACCUM:
                begin
                    if (samp_reg == LAST_SAMPLE)
                    begin
                        sum_reg     <= '0;
                        samp_reg    <= '0;
                        ep_end_reg  <= 1'b1;
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIV;
                    end
                    else
                    begin
                        sum_reg   <= sum_next;
                        samp_reg  <= samp_reg + 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == lmsn_pkg::DIV_CNT_W'(lmsn_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= ST_EPOCH;
                    end
                end
                ST_EPOCH:
                begin
                    conv_reg  <= conv_next;
                    epoch_reg <= epoch_next;
                    if (conv_next || (epoch_next >= epoch_limit))
                    begin
                        done_reg <= 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    // hold the result until the output register frees up
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/lms_neuron_online_trainer_core.sv
`timescale 1ns / 1ps

// Single linear neuron trained online by the LMS delta rule.
// Input channel s_*: one training sample per item (three Q4.12 inputs, a Q4.12
// target, and a restart flag in s_tuser that reloads the init weights first).
// Output channel m_*: one result per sample with the prediction, squared error,
// epoch mean and the updated weights; m_tlast marks the sample closing an epoch.
// APB port: learning rate, threshold, epoch limit and init weights at 8*i;
// write only while no sample is in flight.
// The back end works one sample at a time through the shared multiplier
// sequencer; the sample that ends an epoch adds a divide for the mean, and
// the weight update steps are skipped once the weights are frozen.
// A two-item queue in front takes new samples while one is being worked on.
// Reset loads the register defaults and weights of 2.0 and clears all counters.
// If m_tready stays low the result is held in the output register, the back
// end stalls when its next result is ready, and s_tready drops once the queue
// is full.
module lms_neuron_online_trainer_core
#(
    parameter int SAMPLES_PER_EPOCH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [63:0]     s_tdata,   // x_a, x_b, x_c, target
    input  logic [0:0]      s_tuser,   // restart
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [223:0]    m_tdata,   // prediction, squared_error, mean_error,
                                       // weight_a_out, weight_b_out, weight_c_out
    output logic            m_tlast,   // epoch_end
    output logic [1:0]      m_tuser,   // converged, training_active
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [5:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output logic            pready
);

    localparam logic [2:0] REG_LEARNING_RATE   = 3'd0;
    localparam logic [2:0] REG_ERROR_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_MAX_EPOCHS      = 3'd2;
    localparam logic [2:0] REG_INIT_WEIGHT_A   = 3'd3;
    localparam logic [2:0] REG_INIT_WEIGHT_B   = 3'd4;
    localparam logic [2:0] REG_INIT_WEIGHT_C   = 3'd5;

    lmsn_pkg::cfg_t     cfg_reg;
    logic [2:0]         reg_sel;
    logic               wr_en;
    logic               q_valid;
    logic               q_pop;
    lmsn_pkg::item_t    q_item;
    lmsn_pkg::result_t  res;

    assign pready  = 1'b1;
    assign reg_sel = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learning_rate   <= lmsn_pkg::LEARNING_RATE_RESET;
            cfg_reg.error_threshold <= lmsn_pkg::ERROR_THRESHOLD_RESET;
            cfg_reg.max_epochs      <= lmsn_pkg::MAX_EPOCHS_RESET;
            for (int k = 0; k < lmsn_pkg::INPUT_COUNT; k++)
            begin
                cfg_reg.init_weight[k] <= lmsn_pkg::INIT_WEIGHT_RESET;
            end
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_LEARNING_RATE:   cfg_reg.learning_rate   <= pwdata[15:0];
                REG_ERROR_THRESHOLD: cfg_reg.error_threshold <= pwdata[47:0];
                REG_MAX_EPOCHS:      cfg_reg.max_epochs      <= pwdata[15:0];
                REG_INIT_WEIGHT_A:   cfg_reg.init_weight[0]  <= pwdata[31:0];
                REG_INIT_WEIGHT_B:   cfg_reg.init_weight[1]  <= pwdata[31:0];
                REG_INIT_WEIGHT_C:   cfg_reg.init_weight[2]  <= pwdata[31:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_LEARNING_RATE:   prdata = {48'd0, cfg_reg.learning_rate};
            REG_ERROR_THRESHOLD: prdata = {16'd0, cfg_reg.error_threshold};
            REG_MAX_EPOCHS:      prdata = {48'd0, cfg_reg.max_epochs};
            REG_INIT_WEIGHT_A:   prdata = {32'd0, cfg_reg.init_weight[0]};
            REG_INIT_WEIGHT_B:   prdata = {32'd0, cfg_reg.init_weight[1]};
            REG_INIT_WEIGHT_C:   prdata = {32'd0, cfg_reg.init_weight[2]};
            default:             prdata = 64'd0;
        endcase
    end

    lmsn_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    lmsn_back
    #(
        .SAMPLES_PER_EPOCH (SAMPLES_PER_EPOCH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {res.weight_c_out, res.weight_b_out, res.weight_a_out,
                      res.mean_error, res.squared_error, res.prediction};
    assign m_tlast = res.epoch_end;
    assign m_tuser = {res.training_active, res.converged};

endmodule

FILE: rtl/lmsn_checker.sv
`timescale 1ns / 1ps

module lmsn_checker
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  logic            m_tlast,
    input  logic [1:0]      m_tuser,
    input  logic [223:0]    m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    // convergence is only reported at an epoch boundary
    a_conv_at_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("converged without epoch end");

    // an epoch only closes on a training sample
    a_epoch_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("epoch end on a frozen sample");

    // mean field is zero away from epoch ends
    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[127:80] == 48'd0)
        else $error("mean error nonzero outside epoch end");

endmodule

bind lms_neuron_online_trainer_core lmsn_checker u_lmsn_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);
